@@ sv/smx_pkg.sv @@
// smx_pkg: shared types and constants of the stack machine executor
// no dependencies; imported by every module of the block but smx_ram
package smx_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MEM_DEPTH_DEFAULT = 1024;   // power of two
   localparam int SP_BITS = 10;
   localparam int IMM_BITS = 32;
   localparam int OPC_BITS = 6;
   localparam int TOP_BITS = 32;
   localparam int STATUS_BITS = 3;
   localparam int REQ_BYTES_BITS = 40;
   localparam int RSP_BYTES_BITS = 48;

   typedef enum logic [OPC_BITS-1:0] {
      OP_CONST = 6'd0,  OP_LDG  = 6'd1,  OP_LDL  = 6'd2,  OP_LDGX = 6'd3,
      OP_LDLX  = 6'd4,  OP_ADD  = 6'd5,  OP_SUB  = 6'd6,  OP_MUL  = 6'd7,
      OP_DIV   = 6'd8,  OP_MOD  = 6'd9,  OP_OR   = 6'd10, OP_AND  = 6'd11,
      OP_XOR   = 6'd12, OP_SHL  = 6'd13, OP_SHR  = 6'd14, OP_LAND = 6'd15,
      OP_LOR   = 6'd16, OP_NEG  = 6'd17, OP_NOT  = 6'd18, OP_LNOT = 6'd19,
      OP_STG   = 6'd20, OP_STL  = 6'd21, OP_STGX = 6'd22, OP_STLX = 6'd23,
      OP_CHK   = 6'd24, OP_RET  = 6'd25, OP_CBRA = 6'd26, OP_BRA  = 6'd27,
      OP_EQ    = 6'd28, OP_NE   = 6'd29, OP_GT   = 6'd30, OP_LT   = 6'd31,
      OP_GE    = 6'd32, OP_LE   = 6'd33, OP_END  = 6'd34, OP_MOVE = 6'd35,
      OP_NOP   = 6'd36
   } op_type;

   localparam logic [OPC_BITS-1:0] OP_LAST = 6'd36;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 3'd0,
      ST_END  = 3'd1,
      ST_NEG  = 3'd2,
      ST_BIG  = 3'd3,
      ST_DIVZ = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MD_MUL = 2'd0,
      MD_DIV = 2'd1,
      MD_MOD = 2'd2
   } md_type;

   typedef struct packed {
      op_type               op;
      logic [IMM_BITS-1:0]  imm;
   } item_type;

   typedef struct packed {
      logic    start;
      md_type  kind;
   } md_ctl_type;

endpackage

@@ sv/smx_ram.sv @@
// smx_ram: generic single-write, single-read ram with registered read data
// no dependencies
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/smx_front.sv @@
// smx_front: accepts instruction beats, decodes the opcode and queues them
// depends on smx_pkg
module smx_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [smx_pkg::OPC_BITS-1:0] in_op,
   input  logic [smx_pkg::IMM_BITS-1:0] in_imm,
   output logic                        q_valid,
   output smx_pkg::item_type           q_item,
   input  logic                        q_pop
);
   import smx_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   dec;

   // opcodes past the last one behave as nop
   always_comb begin
      dec.imm = in_imm;
      dec.op  = (in_op > OP_LAST) ? OP_NOP : op_type'(in_op);
   end

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

@@ sv/smx_mdu.sv @@
// smx_mdu: one-bit-per-cycle multiply and signed divide / modulo unit
// depends on smx_pkg; divisor is never zero when started
module smx_mdu #(
   parameter int WORD_BITS = smx_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smx_pkg::md_ctl_type  ctl,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   output logic                 done,
   output logic [WORD_BITS-1:0] result
);
   import smx_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = $clog2(WORD_BITS + 1);

   logic          busy_ff, done_ff, neg_ff;
   md_type        kind_ff;
   logic [CW-1:0] cnt_ff;
   logic [W:0]    acc_ff;
   logic [W-1:0]  x_ff, y_ff;
   logic [W:0]    rs;
   logic [W-1:0]  abs_a, abs_b;

   assign abs_a = a[W-1] ? (~a + 1'b1) : a;
   assign abs_b = b[W-1] ? (~b + 1'b1) : b;
   assign rs    = {acc_ff[W-1:0], x_ff[W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (ctl.start) begin
         kind_ff <= ctl.kind;
         cnt_ff  <= CW'(W);
         acc_ff  <= '0;
         if (ctl.kind == MD_MUL) begin
            x_ff <= a;
            y_ff <= b;
         end else begin
            x_ff <= abs_a;
            y_ff <= abs_b;
         end
         neg_ff <= (ctl.kind == MD_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (kind_ff == MD_MUL) begin
            if (y_ff[0]) begin
               acc_ff <= {1'b0, acc_ff[W-1:0] + x_ff};
            end
            x_ff <= x_ff << 1;
            y_ff <= y_ff >> 1;
         end else if (rs >= {1'b0, y_ff}) begin
            // restoring step: subtract and shift in a one
            acc_ff <= rs - {1'b0, y_ff};
            x_ff   <= {x_ff[W-2:0], 1'b1};
         end else begin
            acc_ff <= rs;
            x_ff   <= {x_ff[W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      case (kind_ff)
         MD_MUL:  result = acc_ff[W-1:0];
         MD_DIV:  result = neg_ff ? (~x_ff + 1'b1) : x_ff;
         MD_MOD:  result = neg_ff ? (~acc_ff[W-1:0] + 1'b1) : acc_ff[W-1:0];
         default: result = acc_ff[W-1:0];
      endcase
   end

   assign done = done_ff;
endmodule

@@ sv/smx_back.sv @@
// smx_back: sequencer that executes queued instructions on the data memory
// depends on smx_pkg, smx_ram, smx_mdu
module smx_back #(
   parameter int WORD_BITS = smx_pkg::WORD_BITS_DEFAULT,
   parameter int MEM_DEPTH = smx_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [smx_pkg::SP_BITS-1:0]     frame_base,
   input  logic                           q_valid,
   input  smx_pkg::item_type              q_item,
   output logic                           q_pop,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [smx_pkg::TOP_BITS-1:0]    out_top,
   output logic                           out_branch,
   output logic [smx_pkg::SP_BITS-1:0]     out_depth,
   output logic [smx_pkg::STATUS_BITS-1:0] out_status
);
   import smx_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int AW = $clog2(MEM_DEPTH);
   localparam int SW = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      S_IDLE, S_RDA, S_EXEC, S_LOAD, S_MD, S_TOP, S_TOPW
   } state_type;

   state_type            state_ff;
   item_type             item_ff;
   logic [SP_BITS-1:0]   sp_ff;
   logic [W-1:0]         b_ff;
   logic [AW-1:0]        wa_ff;
   logic                 brk_ff;
   status_type           status_ff;
   logic                 out_valid_ff;
   logic [TOP_BITS-1:0]  out_top_ff;
   logic                 out_branch_ff;
   logic [SP_BITS-1:0]   out_depth_ff;
   logic [STATUS_BITS-1:0] out_status_ff;

   logic                 we, re;
   logic [AW-1:0]        waddr, raddr;
   logic [W-1:0]         wdata, rdata;
   md_ctl_type           md_ctl;
   logic                 md_done;
   logic [W-1:0]         md_result;

   logic [W-1:0]         a, b, imm_w, alu_r;
   logic signed [63:0]   imm64;
   logic [AW-1:0]        base_g, base_l, ld_addr, st_addr;
   logic                 big_shift;
   logic [SP_BITS-1:0]   sp_in;
   logic                 brk_in;
   status_type           status_in;
   logic                 out_load;

   function automatic logic [AW-1:0] stk(input logic [SP_BITS-1:0] fb,
                                         input logic [SP_BITS-1:0] pos);
      logic [SP_BITS:0] sum;
      sum = {1'b0, fb} + {1'b0, pos};
      return AW'(sum);
   endfunction

   assign a         = rdata;
   assign b         = b_ff;
   assign imm64     = 64'(signed'(item_ff.imm));
   assign imm_w     = imm64[W-1:0];
   assign base_g    = item_ff.imm[AW-1:0];
   assign base_l    = AW'(frame_base) + item_ff.imm[AW-1:0];
   assign big_shift = (b >= W'(WORD_BITS));
   assign out_load  = !out_valid_ff || out_ready;

   always_comb begin
      case (item_ff.op)
         OP_LDG:  ld_addr = base_g;
         OP_LDL:  ld_addr = base_l;
         OP_LDGX: ld_addr = base_g + b[AW-1:0];
         default: ld_addr = base_l + b[AW-1:0];
      endcase
      case (item_ff.op)
         OP_STG:  st_addr = base_g;
         OP_STL:  st_addr = base_l;
         OP_STGX: st_addr = base_g + a[AW-1:0];
         default: st_addr = base_l + a[AW-1:0];
      endcase
   end

   always_comb begin
      case (item_ff.op)
         OP_ADD:  alu_r = a + b;
         OP_SUB:  alu_r = a - b;
         OP_OR:   alu_r = a | b;
         OP_AND:  alu_r = a & b;
         OP_XOR:  alu_r = a ^ b;
         OP_SHL:  alu_r = big_shift ? '0 : (a << b[SW-1:0]);
         OP_SHR:  alu_r = big_shift ? {W{a[W-1]}} : W'(signed'(a) >>> b[SW-1:0]);
         OP_LAND: alu_r = {{(W-1){1'b0}}, (a != '0) && (b != '0)};
         OP_LOR:  alu_r = {{(W-1){1'b0}}, (a != '0) || (b != '0)};
         OP_EQ:   alu_r = {{(W-1){1'b0}}, a == b};
         OP_NE:   alu_r = {{(W-1){1'b0}}, a != b};
         OP_GT:   alu_r = {{(W-1){1'b0}}, signed'(b) < signed'(a)};
         OP_LT:   alu_r = {{(W-1){1'b0}}, signed'(a) < signed'(b)};
         OP_GE:   alu_r = {{(W-1){1'b0}}, !(signed'(a) < signed'(b))};
         OP_LE:   alu_r = {{(W-1){1'b0}}, !(signed'(b) < signed'(a))};
         default: alu_r = '0;
      endcase
   end

   // memory port control and next stack pointer
   always_comb begin
      we        = 1'b0;
      waddr     = wa_ff;
      wdata     = md_result;
      re        = 1'b0;
      raddr     = stk(frame_base, sp_ff - 1'b1);
      q_pop     = 1'b0;
      md_ctl    = '{start: 1'b0, kind: MD_MUL};
      sp_in     = sp_ff;
      brk_in    = 1'b0;
      status_in = ST_OK;
      case (state_ff)
         S_IDLE: begin
            q_pop = q_valid;
            re    = q_valid;
            raddr = stk(frame_base, sp_ff - 1'b1);
         end
         S_RDA: begin
            re    = 1'b1;
            raddr = stk(frame_base, sp_ff - 2'd2);
         end
         S_EXEC: begin
            case (item_ff.op)
               OP_CONST: begin
                  we = 1'b1; waddr = stk(frame_base, sp_ff); wdata = imm_w;
                  sp_in = sp_ff + 1'b1;
               end
               OP_LDG, OP_LDL: begin
                  re = 1'b1; raddr = ld_addr; sp_in = sp_ff + 1'b1;
               end
               OP_LDGX, OP_LDLX: begin
                  re = 1'b1; raddr = ld_addr;
               end
               OP_ADD, OP_SUB, OP_OR, OP_AND, OP_XOR, OP_SHL, OP_SHR,
               OP_LAND, OP_LOR, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
                  we = 1'b1; waddr = stk(frame_base, sp_ff - 2'd2); wdata = alu_r;
                  sp_in = sp_ff - 1'b1;
               end
               OP_MUL, OP_DIV, OP_MOD: begin
                  sp_in = sp_ff - 1'b1;
                  if (item_ff.op != OP_MUL && b == '0) begin
                     we = 1'b1; waddr = stk(frame_base, sp_ff - 2'd2); wdata = '0;
                     status_in = ST_DIVZ;
                  end else begin
                     md_ctl.start = 1'b1;
                     md_ctl.kind  = (item_ff.op == OP_MUL) ? MD_MUL :
                                    (item_ff.op == OP_DIV) ? MD_DIV : MD_MOD;
                  end
               end
               OP_NEG: begin
                  we = 1'b1; waddr = stk(frame_base, sp_ff - 1'b1); wdata = ~b + 1'b1;
               end
               OP_NOT: begin
                  we = 1'b1; waddr = stk(frame_base, sp_ff - 1'b1); wdata = ~b;
               end
               OP_LNOT: begin
                  we = 1'b1; waddr = stk(frame_base, sp_ff - 1'b1);
                  wdata = {{(W-1){1'b0}}, b == '0};
               end
               OP_STG, OP_STL: begin
                  we = 1'b1; waddr = st_addr; wdata = b; sp_in = sp_ff - 1'b1;
               end
               OP_STGX, OP_STLX: begin
                  we = 1'b1; waddr = st_addr; wdata = b; sp_in = sp_ff - 2'd2;
               end
               OP_CHK: begin
                  if (b[W-1]) begin
                     status_in = ST_NEG;
                  end else if (signed'(64'(signed'(b))) >= imm64) begin
                     status_in = ST_BIG;
                  end
               end
               OP_RET: begin
                  we = 1'b1; wdata = b;
                  waddr = stk(frame_base, sp_ff + item_ff.imm[SP_BITS-1:0] - 1'b1);
                  sp_in = sp_ff + item_ff.imm[SP_BITS-1:0];
               end
               OP_CBRA: begin
                  sp_in = sp_ff - 1'b1; brk_in = (b == '0);
               end
               OP_BRA:  brk_in = 1'b1;
               OP_END:  status_in = ST_END;
               OP_MOVE: sp_in = sp_ff + item_ff.imm[SP_BITS-1:0];
               default: ;
            endcase
         end
         S_LOAD: begin
            we = 1'b1; waddr = wa_ff; wdata = rdata;
         end
         S_MD: begin
            we = md_done; waddr = wa_ff; wdata = md_result;
         end
         S_TOP: begin
            re    = 1'b1;
            raddr = stk(frame_base, sp_ff - 1'b1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready && state_ff != S_TOPW) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  state_ff <= S_RDA;
               end
            end
            S_RDA: begin
               b_ff     <= rdata;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               sp_ff     <= sp_in;
               brk_ff    <= brk_in;
               status_ff <= status_in;
               case (item_ff.op)
                  OP_LDG, OP_LDL: begin
                     wa_ff <= stk(frame_base, sp_ff); state_ff <= S_LOAD;
                  end
                  OP_LDGX, OP_LDLX: begin
                     wa_ff <= stk(frame_base, sp_ff - 1'b1); state_ff <= S_LOAD;
                  end
                  default: begin
                     wa_ff    <= stk(frame_base, sp_ff - 2'd2);
                     state_ff <= md_ctl.start ? S_MD : S_TOP;
                  end
               endcase
            end
            S_LOAD: state_ff <= S_TOP;
            S_MD: begin
               if (md_done) begin
                  state_ff <= S_TOP;
               end
            end
            S_TOP: state_ff <= S_TOPW;
            S_TOPW: begin
               if (out_load) begin
                  out_valid_ff  <= 1'b1;
                  out_top_ff    <= TOP_BITS'(64'(signed'(rdata)));
                  out_branch_ff <= brk_ff;
                  out_depth_ff  <= sp_ff;
                  out_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   smx_ram #(.WIDTH(W), .DEPTH(MEM_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   smx_mdu #(.WORD_BITS(W)) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (md_ctl),
      .a      (a),
      .b      (b),
      .done   (md_done),
      .result (md_result)
   );

   assign out_valid  = out_valid_ff;
   assign out_top    = out_top_ff;
   assign out_branch = out_branch_ff;
   assign out_depth  = out_depth_ff;
   assign out_status = out_status_ff;

   a_sp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOPW) |=> $stable(sp_ff))
      else $error("stack pointer moved while the result waits");
   a_md_start: assert property (@(posedge clock) disable iff (reset)
      md_ctl.start |-> (state_ff == S_EXEC))
      else $error("multiply/divide started outside execute");
   a_no_late_write: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff != S_TOP && state_ff != S_TOPW && state_ff != S_IDLE))
      else $error("memory write during top-of-stack read");
   a_out_from_top: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_TOPW))
      else $error("result raised outside the top-of-stack state");
endmodule

@@ sv/stack_machine_executor.sv @@
// Stack machine executor: runs one bytecode instruction per request beat on a
// word stack kept in a single data memory and returns top of stack, branch
// flag, stack depth and status per instruction. A two-entry queue decouples
// the request side from the executor, and a result register decouples the
// response side. Each instruction steps through S_IDLE, S_RDA, S_EXEC, S_TOP
// and S_TOPW; loads add S_LOAD, and multiply, divide and modulo with a nonzero
// divisor add S_MD to wait on the one-bit-per-cycle multiply/divide unit. The
// single memory read port fetches operands and the new top in turn. MEM_DEPTH
// must be a power of two. Memory contents are undefined until written.
// depends on smx_pkg, smx_front, smx_back
module stack_machine_executor #(
   parameter int WORD_BITS = smx_pkg::WORD_BITS_DEFAULT,
   parameter int MEM_DEPTH = smx_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [smx_pkg::REQ_BYTES_BITS-1:0]  req_tdata,  // op, imm, zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [smx_pkg::RSP_BYTES_BITS-1:0]  rsp_tdata,  // top_value, branch_taken,
                                                           // stack_depth, status, pad
   input  logic                                csr_we,
   input  logic [smx_pkg::SP_BITS-1:0]         csr_wdata   // frame_base
);
   import smx_pkg::*;

   localparam int RSP_USED = TOP_BITS + 1 + SP_BITS + STATUS_BITS;

   logic [SP_BITS-1:0]     frame_base_ff;
   logic                   q_valid, q_pop;
   item_type               q_item;
   logic [TOP_BITS-1:0]    top;
   logic                   branch;
   logic [SP_BITS-1:0]     depth;
   logic [STATUS_BITS-1:0] status;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
      end else if (csr_we) begin
         frame_base_ff <= csr_wdata;
      end
   end

   smx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (req_tdata[OPC_BITS-1:0]),
      .in_imm   (req_tdata[OPC_BITS +: IMM_BITS]),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   smx_back #(.WORD_BITS(WORD_BITS), .MEM_DEPTH(MEM_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .frame_base (frame_base_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_top    (top),
      .out_branch (branch),
      .out_depth  (depth),
      .out_status (status)
   );

   assign rsp_tdata = {{(RSP_BYTES_BITS-RSP_USED){1'b0}}, status, depth, branch, top};
endmodule

@@ verif/testbench.sv @@
// testbench for stack_machine_executor: directed and random instruction streams
// checked beat by beat against an in-bench model of the stack machine
// depends on smx_pkg and stack_machine_executor
`timescale 1ns / 1ps

module testbench;
   import smx_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [REQ_BYTES_BITS-1:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_BYTES_BITS-1:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [SP_BITS-1:0] csr_wdata = '0;

   // packed from the top bit down, so top sits in the lowest bits
   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  depth;
      logic        brk;
      logic [31:0] top;
   } outcome_t;

   // model state
   logic [31:0] mem_words [0:1023];
   bit          mem_known [0:1023];
   logic [9:0]  sp_model;
   logic [9:0]  base_model;

   outcome_t expected_q[$];
   int  errors = 0;
   int  send_idle = 0;
   int  recv_idle = 0;

   stack_machine_executor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [9:0] stack_addr(logic [9:0] off);
      logic [9:0] pos;
      pos = sp_model + off;
      return base_model + pos;
   endfunction

   function automatic bit readable(logic [9:0] addr);
      return mem_known[addr];
   endfunction

   function automatic void mem_write(logic [9:0] addr, logic [31:0] v);
      mem_words[addr] = v;
      mem_known[addr] = 1'b1;
   endfunction

   function automatic logic [31:0] mem_read(logic [9:0] addr);
      return mem_known[addr] ? mem_words[addr] : 32'd0;
   endfunction

   // execute one instruction on the model, return the expected response
   function automatic outcome_t execute(op_type op, logic [31:0] imm);
      outcome_t o;
      logic [31:0] a, b, r, qa, qb;
      logic [9:0] fb;
      fb = base_model;
      a = mem_read(stack_addr(10'h3fe));
      b = mem_read(stack_addr(10'h3ff));
      o = '0;
      r = '0;
      case (op)
         OP_CONST: begin mem_write(stack_addr(10'd0), imm); sp_model++; end
         OP_LDG: begin mem_write(stack_addr(10'd0), mem_read(imm[9:0])); sp_model++; end
         OP_LDL: begin
            mem_write(stack_addr(10'd0), mem_read(fb + imm[9:0])); sp_model++;
         end
         OP_LDGX: mem_write(stack_addr(10'h3ff), mem_read(imm[9:0] + b[9:0]));
         OP_LDLX: mem_write(stack_addr(10'h3ff), mem_read(fb + imm[9:0] + b[9:0]));
         OP_NEG: mem_write(stack_addr(10'h3ff), -b);
         OP_NOT: mem_write(stack_addr(10'h3ff), ~b);
         OP_LNOT: mem_write(stack_addr(10'h3ff), {31'd0, b == 0});
         OP_STG: begin mem_write(imm[9:0], b); sp_model--; end
         OP_STL: begin mem_write(fb + imm[9:0], b); sp_model--; end
         OP_STGX: begin mem_write(imm[9:0] + a[9:0], b); sp_model -= 2; end
         OP_STLX: begin mem_write(fb + imm[9:0] + a[9:0], b); sp_model -= 2; end
         OP_CHK: begin
            if (b[31]) o.status = ST_NEG;
            else if ($signed(b) >= $signed(imm)) o.status = ST_BIG;
         end
         OP_RET: begin
            mem_write(stack_addr(imm[9:0] - 10'd1), b);
            sp_model += imm[9:0];
         end
         OP_CBRA: begin sp_model--; o.brk = (b == 0); end
         OP_BRA: o.brk = 1'b1;
         OP_END: o.status = ST_END;
         OP_MOVE: sp_model += imm[9:0];
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR, OP_SHL,
         OP_SHR, OP_LAND, OP_LOR, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
            case (op)
               OP_ADD: r = a + b;
               OP_SUB: r = a - b;
               OP_MUL: r = a * b;
               OP_DIV, OP_MOD: begin
                  if (b == 0) o.status = ST_DIVZ;
                  else begin
                     qa = a[31] ? -a : a;
                     qb = b[31] ? -b : b;
                     if (op == OP_DIV) begin
                        r = qa / qb;
                        if (a[31] ^ b[31]) r = -r;
                     end else begin
                        r = qa % qb;
                        if (a[31]) r = -r;
                     end
                  end
               end
               OP_OR: r = a | b;
               OP_AND: r = a & b;
               OP_XOR: r = a ^ b;
               OP_SHL: r = (b >= 32) ? 32'd0 : a << b[4:0];
               OP_SHR: r = (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
               OP_LAND: r = {31'd0, a != 0 && b != 0};
               OP_LOR: r = {31'd0, a != 0 || b != 0};
               OP_EQ: r = {31'd0, a == b};
               OP_NE: r = {31'd0, a != b};
               OP_GT: r = {31'd0, $signed(a) > $signed(b)};
               OP_LT: r = {31'd0, $signed(a) < $signed(b)};
               OP_GE: r = {31'd0, $signed(a) >= $signed(b)};
               default: r = {31'd0, $signed(a) <= $signed(b)};
            endcase
            mem_write(stack_addr(10'h3fe), r);
            sp_model--;
         end
         default: ;
      endcase
      o.top = mem_read(stack_addr(10'h3ff));
      o.depth = sp_model;
      return o;
   endfunction

   // true when running op would read a word that was never written
   function automatic bit reads_unknown(op_type op, logic [31:0] imm);
      logic [31:0] a, b;
      logic [9:0] fb, after;
      fb = base_model;
      a = mem_read(stack_addr(10'h3fe));
      b = mem_read(stack_addr(10'h3ff));
      // only the operands an op actually uses must be known
      case (op)
         OP_CONST, OP_LDG, OP_LDL, OP_BRA, OP_END, OP_MOVE, OP_NOP: ;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR, OP_SHL,
         OP_SHR, OP_LAND, OP_LOR, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE,
         OP_STGX, OP_STLX: begin
            if (!readable(stack_addr(10'h3fe)) || !readable(stack_addr(10'h3ff)))
               return 1;
         end
         default: if (!readable(stack_addr(10'h3ff))) return 1;
      endcase
      case (op)
         OP_LDG: if (!readable(imm[9:0])) return 1;
         OP_LDL: if (!readable(fb + imm[9:0])) return 1;
         OP_LDGX: if (!readable(imm[9:0] + b[9:0])) return 1;
         OP_LDLX: if (!readable(fb + imm[9:0] + b[9:0])) return 1;
         default: ;
      endcase
      // the new top is read back as well
      case (op)
         OP_CONST, OP_LDG, OP_LDL: after = sp_model;
         OP_STG, OP_STL, OP_CBRA, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR,
         OP_AND, OP_XOR, OP_SHL, OP_SHR, OP_LAND, OP_LOR, OP_EQ, OP_NE, OP_GT,
         OP_LT, OP_GE, OP_LE: after = sp_model - 10'd2;
         OP_STGX, OP_STLX: after = sp_model - 10'd3;
         OP_RET: after = sp_model + imm[9:0] - 10'd1;
         OP_MOVE: after = sp_model + imm[9:0] - 10'd1;
         default: after = sp_model - 10'd1;
      endcase
      if (op == OP_CONST || op == OP_LDG || op == OP_LDL || op == OP_RET) return 0;
      if (op == OP_STG || op == OP_STL || op == OP_STGX || op == OP_STLX) begin
         // a store may hit the word that becomes top
         logic [9:0] dst;
         dst = (op == OP_STG) ? imm[9:0] : (op == OP_STL) ? fb + imm[9:0] :
               (op == OP_STGX) ? imm[9:0] + a[9:0] : fb + imm[9:0] + a[9:0];
         if (dst == base_model + after) return 0;
      end
      return !readable(base_model + after);
   endfunction

   // valid stays up after an accepted beat until the next beat or an idle cycle
   task automatic send_instruction(op_type op, logic [31:0] imm);
      if (reads_unknown(op, imm)) return;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      expected_q.push_back(execute(op, imm));
      req_tdata <= {2'd0, imm, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_and_configure(logic [9:0] fb);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_wdata <= fb;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      base_model = fb;
   endtask

   // receiver and checker
   always @(posedge clock) begin
      outcome_t got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[45:0];
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t unexpected beat %h", $time, got);
            end else begin
               want = expected_q.pop_front();
               if (got.top !== want.top) begin
                  errors++;
                  $display("%0t top exp %h got %h", $time, want.top, got.top);
               end
               if (got.brk !== want.brk) begin
                  errors++;
                  $display("%0t branch exp %b got %b", $time, want.brk, got.brk);
               end
               if (got.depth !== want.depth) begin
                  errors++;
                  $display("%0t depth exp %0d got %0d", $time, want.depth, got.depth);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t status exp %0d got %0d", $time, want.status, got.status);
               end
            end
         end
         rsp_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(40);
         3: return -$urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   // fill the frame so every stack read and frame load has a known word
   task automatic test_fill_frame();
      for (int i = 0; i < 64; i++) send_instruction(OP_CONST, rand_value());
      send_instruction(OP_MOVE, -32'sd64);
      // stack is empty: store words at the top so an empty stack reads known
      send_instruction(OP_MOVE, 32'sd2);
      send_instruction(OP_RET, -32'sd1);
   endtask

   task automatic test_directed();
      send_instruction(OP_MOVE, -32'sd1);
      send_instruction(OP_CONST, 32'h8000_0000);
      send_instruction(OP_CONST, 32'hffff_ffff);
      send_instruction(OP_DIV, 0);
      send_instruction(OP_CONST, 32'h8000_0000);
      send_instruction(OP_CONST, 32'hffff_ffff);
      send_instruction(OP_MOD, 0);
      send_instruction(OP_CONST, 7);
      send_instruction(OP_CONST, 0);
      send_instruction(OP_DIV, 0);
      send_instruction(OP_CONST, 0);
      send_instruction(OP_MOD, 0);
      send_instruction(OP_CONST, 32'h8000_0001);
      send_instruction(OP_CONST, 32'hffff_ffe0);
      send_instruction(OP_SHR, 0);
      send_instruction(OP_CONST, 32);
      send_instruction(OP_SHL, 0);
      send_instruction(OP_CONST, 32'h7fff_ffff);
      send_instruction(OP_CHK, 32'h7fff_ffff);
      send_instruction(OP_CHK, 32'h8000_0000);
      send_instruction(OP_NEG, 0);
      send_instruction(OP_CHK, 5);
      send_instruction(OP_END, 0);
      send_instruction(OP_BRA, -5);
      send_instruction(op_type'(6'd63), 0);
   endtask

   task automatic test_random(int n);
      op_type op;
      logic [31:0] imm;
      for (int i = 0; i < n; i++) begin
         op = op_type'($urandom_range(OP_LAST + 3));
         case ($urandom_range(3))
            0: imm = $urandom;
            1: imm = rand_value();
            default: imm = $urandom_range(63);
         endcase
         if (op == OP_MOVE || op == OP_RET) imm = $signed($urandom_range(6)) - 3;
         if (op == OP_LDL || op == OP_STL || op == OP_LDG || op == OP_STG)
            if ($urandom_range(1)) imm = $urandom_range(63) | ($urandom << 10);
         // keep depth moderate so stack words stay in the written region
         if (sp_model > 40 && sp_model < 1000 && (op == OP_CONST || op == OP_LDL))
            op = OP_ADD;
         send_instruction(op, imm);
      end
   endtask

   initial begin
      for (int i = 0; i < 1024; i++) mem_known[i] = 1'b0;
      sp_model = '0;
      base_model = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 26; recv_idle = 79;
      test_fill_frame();
      test_directed();
      test_random(300);
      drain_and_configure(10'd1023);
      send_idle = 79; recv_idle = 26;
      test_fill_frame();
      test_random(300);
      drain_and_configure(10'd300);
      send_idle = 0; recv_idle = 0;
      test_fill_frame();
      test_random(300);
      drain_and_configure(10'd0);
      test_random(50);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("stack_machine_executor: match");
      else
         $display("stack_machine_executor: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("stack_machine_executor: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
sv/smx_pkg.sv
sv/smx_ram.sv
sv/smx_front.sv
sv/smx_mdu.sv
sv/smx_back.sv
sv/stack_machine_executor.sv
verif/testbench.sv
